@@ rtl/i2c_temp_sensor_register_bank_assert.svh @@
// assertion macros for the temperature sensor register bank
`ifndef I2C_TEMP_SENSOR_REGISTER_BANK_ASSERT_SVH
`define I2C_TEMP_SENSOR_REGISTER_BANK_ASSERT_SVH

// same-cycle implication, checked out of reset
`define I2CTS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define I2CTS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/i2cts_pkg.sv @@
package i2cts_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_READ    = 3'd1,
    CMD_SETTEMP = 3'd2,
    CMD_ENABLE  = 3'd3,
    CMD_DISABLE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_TEMP    = 2'd0,
    REG_CONFIG  = 2'd1,
    REG_LOWLIM  = 2'd2,
    REG_HIGHLIM = 2'd3
  } reg_e;

  localparam logic [11:0] TempReset   = 12'd400;
  localparam logic [7:0]  ConfigReset = 8'h60;
  localparam logic [15:0] LowReset    = 16'h4B00;
  localparam logic [15:0] HighReset   = 16'h5000;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 24;

  typedef struct packed {
    cmd_e        command;
    logic [2:0]  write_length;
    logic [7:0]  write_byte0;
    logic [7:0]  write_byte1;
    logic [7:0]  write_byte2;
    logic [7:0]  read_length;
    logic signed [11:0] temperature_code;
    logic        sample_valid;
  } item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_high;
    logic [7:0] read_low;
    logic [1:0] read_count;
  } result_t;

endpackage

@@ rtl/i2c_temp_sensor_register_bank.sv @@
// pointer-addressed temperature sensor register bank, two-wire bus view
//
// slave stream carries one command per transfer (bus write, bus read, set
// temperature, enable, disable); every command gives exactly one result
// transfer on the master stream with a status bit and up to two read bytes
//
// pipeline: a transfer accepted on the slave stream is registered in the
// input register, evaluated against the register bank combinationally and
// loaded into the result register once that register is free, which then
// raises m_axis_tvalid_o
// throughput: one transfer per cycle while m_axis_tready_i takes each
// result; the bank is updated as a command passes to the result register
//
// reset: pointer selects temperature, temperature 25 C, config 0x60,
// limits 75 C and 80 C, block enabled, both stream stages empty
// stall: a result held on the master side still lets one more transfer
// into the input register; beyond that s_axis_tready_o drops until the
// result is taken, and no state changes while the pipe is held
`include "i2c_temp_sensor_register_bank_assert.svh"

module i2c_temp_sensor_register_bank (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // write_length, write_byte0, write_byte1, write_byte2, read_length,
  // temperature_code, sample_valid
  input  logic [i2cts_pkg::InDataW-1:0]  s_axis_tdata_i,
  // command
  input  logic [i2cts_pkg::InUserW-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // status, read_high, read_low, read_count, zero pad
  output logic [i2cts_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import i2cts_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    out_ready;   // result register free or being drained
  logic    fire;        // one command is evaluated this cycle
  result_t result;

  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  assign out_ready = !out_valid_q || m_axis_tready_i;
  assign fire      = item_valid && out_ready;

  i2cts_in_reg u_in_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .advance_i       (out_ready),
    .item_valid_o    (item_valid),
    .item_o          (item)
  );

  // register bank and command decode
  i2cts_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .result_o (result)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready) begin
      out_valid_d = fire;
      if (fire) begin
        out_d = result;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, out_q.read_count, out_q.read_low,
                            out_q.read_high, out_q.status};

  // an evaluated command always lands in the result register
  `I2CTS_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, fire, m_axis_tvalid_o,
    "evaluated command produced no result")
  // a read that returns bytes never reports an error
  `I2CTS_ASSERT_SAME(a_read_no_error, clk_i, rst_ni,
    m_axis_tvalid_o && (out_q.read_count != 2'd0), !out_q.status,
    "read with bytes flagged as error")
  // no more than two bytes come back
  `I2CTS_ASSERT_SAME(a_count_range, clk_i, rst_ni, m_axis_tvalid_o,
    out_q.read_count != 2'd3, "read count out of range")
  // bytes beyond the count read as zero
  `I2CTS_ASSERT_SAME(a_short_read_zero, clk_i, rst_ni,
    m_axis_tvalid_o && (out_q.read_count != 2'd2), out_q.read_low == 8'h00,
    "unreturned low byte not zero")

endmodule

@@ rtl/i2cts_in_reg.sv @@
module i2cts_in_reg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [i2cts_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic [i2cts_pkg::InUserW-1:0]  s_axis_tuser_i,
  input  logic                           advance_i,
  output logic                           item_valid_o,
  output i2cts_pkg::item_t               item_o
);
  import i2cts_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  assign s_axis_tready_o = !valid_q || advance_i;
  assign load            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  // unpack tdata, lowest field first
  always_comb begin
    item_d                  = item_q;
    if (load) begin
      item_d.command          = cmd_e'(s_axis_tuser_i);
      item_d.write_length     = s_axis_tdata_i[2:0];
      item_d.write_byte0      = s_axis_tdata_i[10:3];
      item_d.write_byte1      = s_axis_tdata_i[18:11];
      item_d.write_byte2      = s_axis_tdata_i[26:19];
      item_d.read_length      = s_axis_tdata_i[34:27];
      item_d.temperature_code = s_axis_tdata_i[46:35];
      item_d.sample_valid     = s_axis_tdata_i[47];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ rtl/i2cts_core.sv @@
module i2cts_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  i2cts_pkg::item_t    item_i,
  output i2cts_pkg::result_t  result_o
);
  import i2cts_pkg::*;

  reg_e        pointer_q, pointer_d;
  logic [11:0] temp_q, temp_d;
  logic [7:0]  config_q, config_d;
  logic [15:0] low_q, low_d;
  logic [15:0] high_q, high_d;
  logic        enabled_q, enabled_d;

  reg_e        new_ptr;
  logic [11:0] read_temp;
  logic [15:0] reg_word;
  logic [1:0]  cnt;
  result_t     res;

  assign new_ptr   = reg_e'(item_i.write_byte0[1:0]);
  // a fresh sample is taken in before a temperature read
  assign read_temp = (item_i.sample_valid) ? item_i.temperature_code : temp_q;
  assign cnt       = (item_i.read_length >= 8'd2) ? 2'd2 : item_i.read_length[1:0];

  always_comb begin
    case (pointer_q)
      REG_TEMP:   reg_word = {read_temp, 4'b0000};
      REG_CONFIG: reg_word = {config_q, 8'h00};
      REG_LOWLIM: reg_word = low_q;
      default:    reg_word = high_q;
    endcase
  end

  always_comb begin
    pointer_d = pointer_q;
    temp_d    = temp_q;
    config_d  = config_q;
    low_d     = low_q;
    high_d    = high_q;
    enabled_d = enabled_q;
    res       = '0;
    case (item_i.command)
      CMD_WRITE: begin
        if (!enabled_q || item_i.write_length == 3'd0 || item_i.write_length > 3'd3) begin
          res.status = 1'b1;
        end else begin
          pointer_d = new_ptr;
          if (item_i.write_length == 3'd2) begin
            if (new_ptr == REG_CONFIG) begin
              config_d = item_i.write_byte1;
            end else begin
              res.status = 1'b1;
            end
          end else if (item_i.write_length == 3'd3) begin
            if (new_ptr == REG_LOWLIM) begin
              low_d = {item_i.write_byte1, item_i.write_byte2};
            end else if (new_ptr == REG_HIGHLIM) begin
              high_d = {item_i.write_byte1, item_i.write_byte2};
            end else begin
              res.status = 1'b1;
            end
          end
        end
      end
      CMD_READ: begin
        if (pointer_q == REG_TEMP) begin
          temp_d = read_temp;
        end
        res.read_count = cnt;
        if (cnt != 2'd0) begin
          res.read_high = reg_word[15:8];
        end
        if (cnt == 2'd2) begin
          res.read_low = reg_word[7:0];
        end
      end
      CMD_SETTEMP: temp_d    = item_i.temperature_code;
      CMD_ENABLE:  enabled_d = 1'b1;
      CMD_DISABLE: enabled_d = 1'b0;
      default:     res.status = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pointer_q <= REG_TEMP;
      temp_q    <= TempReset;
      config_q  <= ConfigReset;
      low_q     <= LowReset;
      high_q    <= HighReset;
      enabled_q <= 1'b1;
    end else if (fire_i) begin
      pointer_q <= pointer_d;
      temp_q    <= temp_d;
      config_q  <= config_d;
      low_q     <= low_d;
      high_q    <= high_d;
      enabled_q <= enabled_d;
    end
  end

  assign result_o = res;

endmodule
